// ----- rtl/bpa_pkg.sv -----
// Shared constants, codes and control structs for the bitmap page allocator.
// No dependencies.
package bpa_pkg;

  localparam int MAX_SPANS_DEF      = 3;
  localparam int PAGES_PER_SPAN_DEF = 4096;
  localparam int PAGE_BITS_DEF      = 12;

  localparam int REG_SPANS = 3;
  localparam int ADDR_W    = 52;
  localparam int FRAME_W   = 40;
  localparam int PAGES_W   = 13;
  localparam int CNT_W     = 14;
  localparam int WORD_BITS = 64;
  localparam int CFG_AW    = 6;
  localparam int CFG_DW    = 64;

  localparam logic [1:0] KIND_ALLOC    = 2'd0;
  localparam logic [1:0] KIND_ALLOC_AT = 2'd1;
  localparam logic [1:0] KIND_FREE     = 2'd2;

  localparam logic [1:0] TYPE_EPHEMERAL = 2'd1;
  localparam logic [1:0] TYPE_PAGETABLE = 2'd2;
  localparam logic [1:0] TYPE_PHYSBLOCK = 2'd3;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_OOM         = 3'd1;
  localparam logic [2:0] ST_NO_SPAN     = 3'd2;
  localparam logic [2:0] ST_ALLOCATED   = 3'd3;
  localparam logic [2:0] ST_NOT_ALLOCED = 3'd4;

  localparam logic [2:0] REG_SPAN_COUNT = 3'd0;
  localparam logic [2:0] REG_S0_START   = 3'd1;
  localparam logic [2:0] REG_S0_PAGES   = 3'd2;
  localparam logic [2:0] REG_S1_START   = 3'd3;
  localparam logic [2:0] REG_S1_PAGES   = 3'd4;
  localparam logic [2:0] REG_S2_START   = 3'd5;
  localparam logic [2:0] REG_S2_PAGES   = 3'd6;

  typedef struct packed {
    logic clear;
    logic start;
    logic scan;
    logic alloc_wr;
    logic oom;
    logic locate;
    logic lread;
    logic nospan;
    logic lexec;
    logic load_out;
  } bpa_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic found;
    logic exhausted;
    logic hit;
  } bpa_sts_t;

endpackage

// ----- rtl/bpa_req_if.sv -----
// Request channel: valid/ready handshake with the request fields.
// Depends on bpa_pkg.
interface bpa_req_if import bpa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        kind;
  logic [1:0]        alloc_type;
  logic [ADDR_W-1:0] phys_addr;

  modport source (output valid, kind, alloc_type, phys_addr, input ready);
  modport sink   (input valid, kind, alloc_type, phys_addr, output ready);
endinterface

// ----- rtl/bpa_rsp_if.sv -----
// Result channel: valid/ready handshake with status, address and page counts.
// Depends on bpa_pkg.
interface bpa_rsp_if import bpa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [2:0]        status;
  logic [ADDR_W-1:0] page_addr;
  logic [CNT_W-1:0]  allocated_total;
  logic [CNT_W-1:0]  ephemeral_total;
  logic [CNT_W-1:0]  pagetable_total;
  logic [CNT_W-1:0]  physblock_total;

  modport source (output valid, status, page_addr, allocated_total, ephemeral_total,
                  pagetable_total, physblock_total, input ready);
  modport sink   (input valid, status, page_addr, allocated_total, ephemeral_total,
                  pagetable_total, physblock_total, output ready);
endinterface

// ----- rtl/bpa_ram.sv -----
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module bpa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 192,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/bpa_ctrl.sv -----
// Controller FSM: clear pass, request dispatch, scan/lookup sequencing, result hand-off.
// Depends on bpa_pkg.
module bpa_ctrl import bpa_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  input  logic [1:0] req_kind,
  output logic       req_ready,
  output logic       rsp_valid,
  input  logic       rsp_ready,
  output bpa_cmd_t   cmd,
  input  bpa_sts_t   sts
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_AWR   = 3'd3;
  localparam logic [2:0] S_LOC   = 3'd4;
  localparam logic [2:0] S_LRD   = 3'd5;
  localparam logic [2:0] S_LEXEC = 3'd6;
  localparam logic [2:0] S_RESP  = 3'd7;

  logic [2:0] state, state_next;
  logic       out_load;

  assign req_ready = (state == S_IDLE);
  assign out_load  = (state == S_RESP) && (!rsp_valid || rsp_ready);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req_valid) begin
          cmd.start = 1'b1;
          unique case (req_kind)
            KIND_ALLOC:    state_next = S_SCAN;
            KIND_ALLOC_AT: state_next = S_LOC;
            KIND_FREE:     state_next = S_LOC;
            default:       state_next = S_RESP;
          endcase
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.found) begin
          state_next = S_AWR;
        end else if (sts.exhausted) begin
          cmd.oom    = 1'b1;
          state_next = S_RESP;
        end
      end
      S_AWR: begin
        cmd.alloc_wr = 1'b1;
        state_next   = S_RESP;
      end
      S_LOC: begin
        cmd.locate = 1'b1;
        state_next = S_LRD;
      end
      S_LRD: begin
        if (sts.hit) begin
          cmd.lread  = 1'b1;
          state_next = S_LEXEC;
        end else begin
          cmd.nospan = 1'b1;
          state_next = S_RESP;
        end
      end
      S_LEXEC: begin
        cmd.lexec  = 1'b1;
        state_next = S_RESP;
      end
      S_RESP: begin
        cmd.load_out = out_load;
        if (out_load) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/bpa_dp.sv -----
// Datapath: span registers, bitmap and type memories, word scan, span lookup, counters.
// Depends on bpa_pkg and bpa_ram.
module bpa_dp import bpa_pkg::*; #(
  parameter int MAX_SPANS      = MAX_SPANS_DEF,
  parameter int PAGES_PER_SPAN = PAGES_PER_SPAN_DEF,
  parameter int PAGE_BITS      = PAGE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  bpa_cmd_t          cmd,
  output bpa_sts_t          sts,
  input  logic [1:0]        req_kind,
  input  logic [1:0]        req_type,
  input  logic [ADDR_W-1:0] req_addr,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_idx,
  input  logic [CFG_DW-1:0] cfg_wdata,
  output logic [CFG_DW-1:0] cfg_rdata,
  output logic [2:0]        out_status,
  output logic [ADDR_W-1:0] out_addr,
  output logic [CNT_W-1:0]  out_used,
  output logic [CNT_W-1:0]  out_eph,
  output logic [CNT_W-1:0]  out_pt,
  output logic [CNT_W-1:0]  out_pb
);

  localparam int NSPAN    = (MAX_SPANS < REG_SPANS) ? MAX_SPANS : REG_SPANS;
  localparam int WPS      = (PAGES_PER_SPAN + WORD_BITS - 1) / WORD_BITS;
  localparam int BM_DEPTH = MAX_SPANS * WPS;
  localparam int BM_AW    = (BM_DEPTH > 1) ? $clog2(BM_DEPTH) : 1;
  localparam int KM_DEPTH = MAX_SPANS * PAGES_PER_SPAN;
  localparam int KM_AW    = $clog2(KM_DEPTH);
  localparam int OFF_W    = $clog2(PAGES_PER_SPAN);
  localparam int WW       = $clog2(WPS + 1);
  localparam int NP_W     = $clog2(PAGES_PER_SPAN + 1);
  localparam int CW       = 18;
  localparam int LW       = 56;
  localparam int BIT_W    = $clog2(WORD_BITS);

  // configuration
  logic [1:0]         span_count;
  logic [FRAME_W-1:0] start_frame [REG_SPANS];
  logic [PAGES_W-1:0] span_pages  [REG_SPANS];
  logic [NP_W-1:0]    np          [REG_SPANS];
  logic [1:0]         nact;

  always_ff @(posedge clk) begin
    if (rst) begin
      span_count <= '0;
      for (int s = 0; s < REG_SPANS; s++) begin
        start_frame[s] <= '0;
        span_pages[s]  <= '0;
      end
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_SPAN_COUNT: span_count     <= cfg_wdata[1:0];
        REG_S0_START:   start_frame[0] <= cfg_wdata[FRAME_W-1:0];
        REG_S0_PAGES:   span_pages[0]  <= cfg_wdata[PAGES_W-1:0];
        REG_S1_START:   start_frame[1] <= cfg_wdata[FRAME_W-1:0];
        REG_S1_PAGES:   span_pages[1]  <= cfg_wdata[PAGES_W-1:0];
        REG_S2_START:   start_frame[2] <= cfg_wdata[FRAME_W-1:0];
        REG_S2_PAGES:   span_pages[2]  <= cfg_wdata[PAGES_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_SPAN_COUNT: cfg_rdata = CFG_DW'(span_count);
      REG_S0_START:   cfg_rdata = CFG_DW'(start_frame[0]);
      REG_S0_PAGES:   cfg_rdata = CFG_DW'(span_pages[0]);
      REG_S1_START:   cfg_rdata = CFG_DW'(start_frame[1]);
      REG_S1_PAGES:   cfg_rdata = CFG_DW'(span_pages[1]);
      REG_S2_START:   cfg_rdata = CFG_DW'(start_frame[2]);
      REG_S2_PAGES:   cfg_rdata = CFG_DW'(span_pages[2]);
      default:        cfg_rdata = '0;
    endcase
  end

  always_comb begin
    for (int s = 0; s < REG_SPANS; s++) begin
      if (CW'(span_pages[s]) > CW'(PAGES_PER_SPAN)) np[s] = NP_W'(PAGES_PER_SPAN);
      else                                          np[s] = NP_W'(span_pages[s]);
    end
    nact = (int'(span_count) > NSPAN) ? 2'(NSPAN) : span_count;
  end

  // latched request
  logic [1:0]        r_kind;
  logic [1:0]        r_type;
  logic [ADDR_W-1:0] r_addr;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      r_kind <= req_kind;
      r_type <= req_type;
      r_addr <= req_addr;
    end
  end

  // memories
  logic                 bm_we, km_we;
  logic [BM_AW-1:0]     bm_waddr, bm_raddr;
  logic [WORD_BITS-1:0] bm_wdata, bm_rdata;
  logic [KM_AW-1:0]     km_waddr, km_raddr;
  logic [1:0]           km_wdata, km_rdata;

  bpa_ram #(.WIDTH(WORD_BITS), .DEPTH(BM_DEPTH)) u_bitmap (
    .clk(clk), .we(bm_we), .waddr(bm_waddr), .wdata(bm_wdata),
    .raddr(bm_raddr), .rdata(bm_rdata)
  );

  bpa_ram #(.WIDTH(2), .DEPTH(KM_DEPTH)) u_kind (
    .clk(clk), .we(km_we), .waddr(km_waddr), .wdata(km_wdata),
    .raddr(km_raddr), .rdata(km_rdata)
  );

  // clear pass
  logic [BM_AW-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) clr_addr <= '0;
    else if (cmd.clear) clr_addr <= clr_addr + 1'b1;
  end

  assign sts.clear_last = (int'(clr_addr) == BM_DEPTH - 1);

  // scan: one word issued per cycle except when stepping to the next span, checked when its data returns
  logic [1:0]           iss_span, d_span, f_span;
  logic [WW-1:0]        iss_word, d_word, f_word;
  logic                 d_valid;
  logic [BIT_W-1:0]     f_bit, free_bit;
  logic [WORD_BITS-1:0] f_data, free_mask, valid_mask;
  logic                 iss_live, iss_in_span;
  logic [CW-1:0]        rem;

  assign iss_live    = (iss_span < nact);
  assign iss_in_span = (CW'({iss_word, BIT_W'(0)}) < CW'(np[iss_span]));
  assign rem         = CW'(np[d_span]) - CW'({d_word, BIT_W'(0)});

  always_comb begin
    if (rem >= CW'(WORD_BITS)) valid_mask = '1;
    else valid_mask = (WORD_BITS'(1) << rem[BIT_W-1:0]) - WORD_BITS'(1);
    free_mask = ~bm_rdata & valid_mask;
    free_bit  = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (free_mask[b]) free_bit = BIT_W'(b);
    end
  end

  assign sts.found     = d_valid && (|free_mask);
  assign sts.exhausted = !d_valid && !iss_live;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      iss_span <= '0;
      iss_word <= '0;
      d_valid  <= 1'b0;
    end else if (cmd.scan) begin
      if (iss_live && iss_in_span) begin
        d_valid  <= 1'b1;
        d_span   <= iss_span;
        d_word   <= iss_word;
        iss_word <= iss_word + 1'b1;
      end else begin
        d_valid <= 1'b0;
        if (iss_live) begin
          iss_span <= iss_span + 1'b1;
          iss_word <= '0;
        end
      end
      if (sts.found) begin
        f_span <= d_span;
        f_word <= d_word;
        f_bit  <= free_bit;
        f_data <= bm_rdata | (WORD_BITS'(1) << free_bit);
      end
    end
  end

  // span lookup
  logic [LW-1:0]    pfn;
  logic             hit_c, l_hit;
  logic [1:0]       span_c, l_span;
  logic [OFF_W-1:0] l_off;
  logic [LW-1:0]    off_c;

  assign pfn = LW'(r_addr[ADDR_W-1:PAGE_BITS]);

  always_comb begin
    hit_c  = 1'b0;
    span_c = '0;
    for (int s = NSPAN - 1; s >= 0; s--) begin
      if ((s < int'(nact)) && (pfn >= LW'(start_frame[s])) &&
          (pfn < LW'(start_frame[s]) + LW'(np[s]))) begin
        hit_c  = 1'b1;
        span_c = 2'(s);
      end
    end
    off_c = pfn - LW'(start_frame[span_c]);
  end

  always_ff @(posedge clk) begin
    if (cmd.locate) begin
      l_hit  <= hit_c;
      l_span <= span_c;
      l_off  <= off_c[OFF_W-1:0];
    end
  end

  assign sts.hit = l_hit;

  logic [BIT_W-1:0] l_bit;
  logic [WW-1:0]    l_word;
  assign l_bit  = BIT_W'(l_off % WORD_BITS);
  assign l_word = WW'(l_off / WORD_BITS);

  // alloc address and page index for the scan hit
  logic [OFF_W-1:0]   f_off;
  logic [FRAME_W:0]   f_frame;
  logic [63:0]        f_byte;
  logic               l_used;

  assign f_off   = OFF_W'(int'(f_word) * WORD_BITS + int'(f_bit));
  assign f_frame = (FRAME_W + 1)'(start_frame[f_span]) + (FRAME_W + 1)'(f_off);
  assign f_byte  = 64'(f_frame) << PAGE_BITS;
  assign l_used  = bm_rdata[l_bit];

  always_comb begin
    bm_raddr = BM_AW'(int'(iss_span) * WPS + int'(iss_word));
    km_raddr = KM_AW'(int'(l_span) * PAGES_PER_SPAN + int'(l_off));
    if (cmd.lread) bm_raddr = BM_AW'(int'(l_span) * WPS + int'(l_word));

    bm_we    = 1'b0;
    bm_waddr = clr_addr;
    bm_wdata = '0;
    km_we    = 1'b0;
    km_waddr = km_raddr;
    km_wdata = r_type;
    if (cmd.clear) begin
      bm_we = 1'b1;
    end else if (cmd.alloc_wr) begin
      bm_we    = 1'b1;
      bm_waddr = BM_AW'(int'(f_span) * WPS + int'(f_word));
      bm_wdata = f_data;
      km_we    = 1'b1;
      km_waddr = KM_AW'(int'(f_span) * PAGES_PER_SPAN + int'(f_off));
    end else if (cmd.lexec) begin
      bm_waddr = BM_AW'(int'(l_span) * WPS + int'(l_word));
      if (r_kind == KIND_ALLOC_AT && !l_used) begin
        bm_we    = 1'b1;
        bm_wdata = bm_rdata | (WORD_BITS'(1) << l_bit);
        km_we    = 1'b1;
      end else if (r_kind == KIND_FREE && l_used) begin
        bm_we    = 1'b1;
        bm_wdata = bm_rdata & ~(WORD_BITS'(1) << l_bit);
      end
    end
  end

  // result and counters
  logic [2:0]        res_status;
  logic [ADDR_W-1:0] res_addr;
  logic [CNT_W-1:0]  used_cnt, eph_cnt, pt_cnt, pb_cnt;
  logic              inc, dec;
  logic [1:0]        inc_type;

  assign inc = cmd.alloc_wr || (cmd.lexec && r_kind == KIND_ALLOC_AT && !l_used);
  assign dec = cmd.lexec && r_kind == KIND_FREE && l_used;
  assign inc_type = dec ? km_rdata : r_type;

  always_ff @(posedge clk) begin
    if (rst) begin
      used_cnt <= '0;
      eph_cnt  <= '0;
      pt_cnt   <= '0;
      pb_cnt   <= '0;
    end else if (inc || dec) begin
      used_cnt <= inc ? used_cnt + 1'b1 : used_cnt - 1'b1;
      unique case (inc_type)
        TYPE_EPHEMERAL: eph_cnt <= inc ? eph_cnt + 1'b1 : eph_cnt - 1'b1;
        TYPE_PAGETABLE: pt_cnt  <= inc ? pt_cnt + 1'b1 : pt_cnt - 1'b1;
        TYPE_PHYSBLOCK: pb_cnt  <= inc ? pb_cnt + 1'b1 : pb_cnt - 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      res_status <= ST_OK;
      res_addr   <= '0;
    end else if (cmd.oom) begin
      res_status <= ST_OOM;
    end else if (cmd.nospan) begin
      res_status <= ST_NO_SPAN;
    end else if (cmd.alloc_wr) begin
      res_addr <= f_byte[ADDR_W-1:0];
    end else if (cmd.lexec) begin
      res_addr <= {r_addr[ADDR_W-1:PAGE_BITS], PAGE_BITS'(0)};
      if (r_kind == KIND_ALLOC_AT && l_used)  res_status <= ST_ALLOCATED;
      else if (r_kind == KIND_FREE && !l_used) res_status <= ST_NOT_ALLOCED;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status <= res_status;
      out_addr   <= res_addr;
      out_used   <= used_cnt;
      out_eph    <= eph_cnt;
      out_pt     <= pt_cnt;
      out_pb     <= pb_cnt;
    end
  end

endmodule

// ----- rtl/bitmap_page_allocator.sv -----
// Top level of the bitmap page allocator: controller, datapath and APB register port.
// Depends on bpa_pkg, bpa_req_if, bpa_rsp_if, bpa_ctrl, bpa_dp.
//
//   channel   dir  handshake              contents
//   req       in   valid/ready            kind, alloc_type, phys_addr
//   rsp       out  valid/ready            status, page_addr, four page counts
//   apb       in   psel/penable/pwrite    span_count, span start frames and sizes
//
// Allocate scans the bitmap one 64-bit word per cycle, except for a slot lost at each
// span change. Allocate-at and free run span compare, bitmap/type read, then write-back.
// After reset a clearing pass writes every bitmap word (192 by default) before the
// first request is taken.
// A result waits in the output register while the next request is accepted.
module bitmap_page_allocator import bpa_pkg::*; #(
  parameter int MAX_SPANS      = MAX_SPANS_DEF,
  parameter int PAGES_PER_SPAN = PAGES_PER_SPAN_DEF,
  parameter int PAGE_BITS      = PAGE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  bpa_req_if.sink           req,
  bpa_rsp_if.source         rsp,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  bpa_cmd_t cmd;
  bpa_sts_t sts;
  logic     cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  bpa_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .req_valid(req.valid), .req_kind(req.kind), .req_ready(req.ready),
    .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
    .cmd(cmd), .sts(sts)
  );

  bpa_dp #(
    .MAX_SPANS(MAX_SPANS), .PAGES_PER_SPAN(PAGES_PER_SPAN), .PAGE_BITS(PAGE_BITS)
  ) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .req_kind(req.kind), .req_type(req.alloc_type), .req_addr(req.phys_addr),
    .cfg_we(cfg_we), .cfg_idx(paddr[5:3]), .cfg_wdata(pwdata), .cfg_rdata(prdata),
    .out_status(rsp.status), .out_addr(rsp.page_addr),
    .out_used(rsp.allocated_total), .out_eph(rsp.ephemeral_total),
    .out_pt(rsp.pagetable_total), .out_pb(rsp.physblock_total)
  );

endmodule
